FILE: sv/page_framebuffer_glyph_plotter_unit_macros.svh
// Assertion macros shared by the glyph plotter RTL.
`ifndef PAGE_FRAMEBUFFER_GLYPH_PLOTTER_UNIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_GLYPH_PLOTTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PGFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PGFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pgfb_pkg.sv
// Types, codes and font table of the page framebuffer glyph plotter.
package pgfb_pkg;

    // Item kinds on the command port
    typedef enum logic [1:0] {
        KIND_GLYPH = 2'd0,
        KIND_PLOT  = 2'd1,
        KIND_READ  = 2'd2
    } pgfb_kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEG,
        ST_WR,
        ST_RDADR,
        ST_RDDAT
    } pgfb_state_t;

    localparam int GLYPH_SIZE   = 5;
    localparam int GLYPH_COUNT  = 13;
    localparam logic [3:0] GLYPH_DOT   = 4'd10;
    localparam logic [3:0] GLYPH_COLON = 4'd11;
    localparam logic [3:0] GLYPH_BLANK = 4'd12;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Five row bytes per glyph, bit 4-c is glyph column c
    localparam logic [7:0] FONT_ROM [0:GLYPH_COUNT*GLYPH_SIZE-1] = '{
        8'h06, 8'h09, 8'h09, 8'h09, 8'h06,
        8'h02, 8'h06, 8'h0A, 8'h02, 8'h02,
        8'h06, 8'h09, 8'h02, 8'h04, 8'h0F,
        8'h06, 8'h09, 8'h03, 8'h09, 8'h06,
        8'h02, 8'h04, 8'h08, 8'h0F, 8'h02,
        8'h0F, 8'h08, 8'h0E, 8'h01, 8'h0E,
        8'h06, 8'h08, 8'h0E, 8'h09, 8'h06,
        8'h0F, 8'h01, 8'h02, 8'h04, 8'h08,
        8'h06, 8'h09, 8'h06, 8'h09, 8'h06,
        8'h06, 8'h09, 8'h07, 8'h01, 8'h06,
        8'h00, 8'h00, 8'h00, 8'h06, 8'h06,
        8'h00, 8'h06, 8'h00, 8'h06, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Map a character code to its glyph slot; unknown codes draw blank
    function automatic logic [3:0] glyph_index(input logic [7:0] code);
        logic [7:0] diff;
        diff = code - CHAR_ZERO;
        if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            return diff[3:0];
        end
        else if (code == CHAR_DOT) begin
            return GLYPH_DOT;
        end
        else if (code == CHAR_COLON) begin
            return GLYPH_COLON;
        end
        return GLYPH_BLANK;
    endfunction

    // One font row, five pixels wide
    function automatic logic [4:0] font_row(input logic [3:0] idx, input logic [2:0] row);
        logic [6:0] addr;
        addr = 7'(idx) * 7'(GLYPH_SIZE) + 7'(row);
        return FONT_ROM[addr][4:0];
    endfunction

endpackage

FILE: sv/pgfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/page_framebuffer_glyph_plotter_unit.sv
// Top level of the page framebuffer glyph plotter: sequencer around one frame RAM.
//
//  channel   | handshake        | words
//  ----------+------------------+-------------------------------------------------
//  command   | start / busy     | kind, pos_x, pos_y, char_code, color, page, column
//  result    | done (strobe)    | read_data
//
// After reset a clearing pass writes zero to every frame byte, one per cycle, across
// DISPLAY_WIDTH * ((DISPLAY_HEIGHT+7)/8) bytes (1024 by default); busy is high.
// A glyph walks 5 columns x 2 pages through one read-modify-write RAM port pair:
// a skipped page slot is only evaluated, a written one is also merged and written back.
// A plot walks one column the same way; a read passes ST_RDADR and ST_RDDAT, then shows done.
// done is high for one cycle and the receiver cannot stall it.
`include "page_framebuffer_glyph_plotter_unit_macros.svh"

module page_framebuffer_glyph_plotter_unit #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        kind,
    input  logic signed [9:0] pos_x,
    input  logic signed [9:0] pos_y,
    input  logic [7:0]        char_code,
    input  logic              color,
    input  logic [2:0]        page,
    input  logic [6:0]        column,
    output logic              done,
    output logic [7:0]        read_data
);

    localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
    localparam int DEPTH      = PAGE_COUNT * DISPLAY_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam int XW         = $clog2(DISPLAY_WIDTH);
    localparam int PGW        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CW         = 11;
    localparam logic signed [CW-1:0] W_S = CW'(DISPLAY_WIDTH);
    localparam logic signed [CW-1:0] H_S = CW'(DISPLAY_HEIGHT);
    localparam int GS         = pgfb_pkg::GLYPH_SIZE;

    // Control registers
    pgfb_pkg::pgfb_state_t state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [2:0]            col_reg, col_next;
    logic                  seg_reg, seg_next;
    logic [2:0]            last_col_reg, last_col_next;
    logic                  done_reg, done_next;

    // Item registers
    logic signed [CW-1:0]  pos_x_reg, pos_x_next;
    logic signed [CW-1:0]  pos_y_reg, pos_y_next;
    logic [GS-1:0][4:0]    rows_reg, rows_next;
    logic [GS-1:0]         en_reg, en_next;
    logic [AW-1:0]         rd_addr_reg, rd_addr_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic [7:0]            read_data_reg, read_data_next;

    // Current column / page slot
    logic signed [CW-1:0]  x_cur;
    logic                  x_ok;
    logic signed [CW-1:0]  seg_page_s;
    logic [7:0]            seg_mask;
    logic [7:0]            seg_val;
    logic                  seg_active;
    logic [AW-1:0]         seg_addr;

    // RAM ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [7:0]            ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [7:0]            ram_rdata;

    logic                  accept;
    logic                  rd_ok_in;
    logic [3:0]            gidx;

    assign busy      = (state_reg != pgfb_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign read_data = read_data_reg;

    pgfb_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_frame_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Column position and page of the current slot
    assign x_cur      = pos_x_reg + signed'(CW'(col_reg));
    assign x_ok       = (x_cur >= 0) && (x_cur < W_S);
    assign seg_page_s = (pos_y_reg >>> 3) + signed'(CW'(seg_reg));
    assign seg_active = x_ok && (seg_mask != 8'd0);
    assign seg_addr   = AW'(32'(seg_page_s[PGW-1:0]) * DISPLAY_WIDTH + 32'(x_cur[XW-1:0]));

    // Bit mask and new bits for the glyph rows that land in this page
    always_comb
    begin : seg_calc
        logic signed [CW-1:0] yr;
        seg_mask = '0;
        seg_val  = '0;
        for (int r = 0; r < GS; r++)
        begin
            yr = pos_y_reg + signed'(CW'(r));
            if (en_reg[r] && (yr >= 0) && (yr < H_S) && ((yr >>> 3) == seg_page_s))
            begin
                seg_mask[yr[2:0]] = 1'b1;
                seg_val[yr[2:0]]  = rows_reg[r][3'd4 - col_reg];
            end
        end
    end

    // Read item address check
    assign rd_ok_in = (32'(page) < PAGE_COUNT) && (32'(column) < DISPLAY_WIDTH);
    assign gidx     = pgfb_pkg::glyph_index(char_code);

    // Sequencer: next state, RAM controls and item capture
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        col_next       = col_reg;
        seg_next       = seg_reg;
        last_col_next  = last_col_reg;
        done_next      = 1'b0;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        rows_next      = rows_reg;
        en_next        = en_reg;
        rd_addr_next   = rd_addr_reg;
        rd_ok_next     = rd_ok_reg;
        read_data_next = read_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = seg_addr;
        ram_wdata      = (ram_rdata & ~seg_mask) | seg_val;
        ram_raddr      = seg_addr;

        unique case (state_reg)
            pgfb_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'd0;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = pgfb_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            pgfb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pos_x_next   = CW'(pos_x);
                    pos_y_next   = CW'(pos_y);
                    col_next     = 3'd0;
                    seg_next     = 1'b0;
                    rd_ok_next   = rd_ok_in;
                    rd_addr_next = rd_ok_in ?
                                   AW'(32'(page) * DISPLAY_WIDTH + 32'(column)) : '0;
                    unique case (kind)
                        pgfb_pkg::KIND_GLYPH:
                        begin
                            for (int r = 0; r < GS; r++)
                            begin
                                rows_next[r] = pgfb_pkg::font_row(gidx, 3'(r));
                            end
                            en_next       = '1;
                            last_col_next = 3'(GS - 1);
                            state_next    = pgfb_pkg::ST_SEG;
                        end
                        pgfb_pkg::KIND_PLOT:
                        begin
                            rows_next     = '0;
                            rows_next[0]  = {color, 4'd0};
                            en_next       = GS'(1);
                            last_col_next = 3'd0;
                            state_next    = pgfb_pkg::ST_SEG;
                        end
                        pgfb_pkg::KIND_READ:
                        begin
                            state_next = pgfb_pkg::ST_RDADR;
                        end
                        default:
                        begin
                            state_next = pgfb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Evaluate slot: fetch its byte, or move on if nothing lands here
            pgfb_pkg::ST_SEG:
            begin
                if (seg_active)
                begin
                    state_next = pgfb_pkg::ST_WR;
                end
                else if (!seg_reg)
                begin
                    seg_next = 1'b1;
                end
                else if (col_reg == last_col_reg)
                begin
                    state_next = pgfb_pkg::ST_IDLE;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                    seg_next = 1'b0;
                end
            end

            // Merge and write back, then move on
            pgfb_pkg::ST_WR:
            begin
                ram_we     = 1'b1;
                state_next = pgfb_pkg::ST_SEG;
                if (!seg_reg)
                begin
                    seg_next = 1'b1;
                end
                else if (col_reg == last_col_reg)
                begin
                    state_next = pgfb_pkg::ST_IDLE;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                    seg_next = 1'b0;
                end
            end

            pgfb_pkg::ST_RDADR:
            begin
                ram_raddr  = rd_addr_reg;
                state_next = pgfb_pkg::ST_RDDAT;
            end

            pgfb_pkg::ST_RDDAT:
            begin
                done_next      = 1'b1;
                read_data_next = rd_ok_reg ? ram_rdata : 8'd0;
                state_next     = pgfb_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = pgfb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pgfb_pkg::ST_CLEAR;
            clr_reg      <= '0;
            col_reg      <= '0;
            seg_reg      <= 1'b0;
            last_col_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            col_reg      <= col_next;
            seg_reg      <= seg_next;
            last_col_reg <= last_col_next;
            done_reg     <= done_next;
        end
    end

    // Item words
    always_ff @(posedge clk)
    begin
        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        rows_reg      <= rows_next;
        en_reg        <= en_next;
        rd_addr_reg   <= rd_addr_next;
        rd_ok_reg     <= rd_ok_next;
        read_data_reg <= read_data_next;
    end

    // Checks
    `PGFB_ASSERT_NEXT(a_done_one_cycle, done_reg, !done_reg,
        "done held longer than one cycle")
    `PGFB_ASSERT_NOW(a_no_write_idle, state_reg == pgfb_pkg::ST_IDLE, !ram_we,
        "RAM write while idle")
    `PGFB_ASSERT_NEXT(a_read_path, accept && (kind == pgfb_pkg::KIND_READ),
        state_reg == pgfb_pkg::ST_RDADR, "read item did not start read")
    `PGFB_ASSERT_NEXT(a_done_from_read, state_reg == pgfb_pkg::ST_RDDAT, done_reg,
        "read finished without done")

endmodule
